// ----- design/sof_pkg.sv -----
// Shared types, constants and the column walk step of the scanline outline fill.
`default_nettype none
package sof_pkg;

  localparam int ROW_W         = 64;
  localparam int MAX_WIDTH_DEF = 64;
  localparam int SEG_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_EN    = 2'd0,
    CFG_OUTLINE_EN = 2'd1,
    CFG_ROW_WIDTH  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic in_run;
    logic filled;
    logic parity;
  } walk_st_t;

  typedef struct packed {
    logic multi;
    logic draw;
  } row_ctrl_t;

  function automatic walk_st_t walk_step(walk_st_t st, logic s, logic multi);
    walk_st_t nxt;
    nxt = st;
    if (st.in_run && st.filled) begin
      if (s) nxt.filled = 1'b0;
    end else if (st.in_run) begin
      if (!s) begin
        if (multi) begin
          if (st.parity) nxt.in_run = 1'b0;
          else nxt.filled = 1'b1;
          nxt.parity = !st.parity;
        end else begin
          nxt.in_run = 1'b0;
        end
      end
    end else if (s) begin
      nxt.in_run = 1'b1;
    end
    return nxt;
  endfunction

endpackage
`default_nettype wire

// ----- design/sof_prep.sv -----
// Front stage: clips the row to its width, builds the fill gate and detects two or more edges.
`default_nettype none
module sof_prep import sof_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [MAX_WIDTH-1:0]  row_i,
  input  wire logic                  fill_en_i,
  input  wire logic                  outline_en_i,
  input  wire logic [CFG_DATA_W-1:0] row_width_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [MAX_WIDTH-1:0]       row_o,
  output logic [MAX_WIDTH-1:0]       fgate_o,
  output row_ctrl_t                  ctrl_o
);

  logic                  valid_r;
  logic [MAX_WIDTH-1:0]  row_r, row_nxt;
  logic [MAX_WIDTH-1:0]  fgate_r, fgate_nxt;
  row_ctrl_t             ctrl_r, ctrl_nxt;
  logic [CFG_DATA_W-1:0] w_eff;
  logic [MAX_WIDTH-1:0]  vmask;
  logic [MAX_WIDTH-1:0]  rise;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    if (row_width_i > CFG_DATA_W'(MAX_WIDTH)) w_eff = CFG_DATA_W'(MAX_WIDTH);
    else w_eff = row_width_i;
    for (int j = 0; j < MAX_WIDTH; j++) begin
      vmask[j] = CFG_DATA_W'(j) < w_eff;
    end
    row_nxt        = row_i & vmask;
    fgate_nxt      = vmask & {MAX_WIDTH{fill_en_i}};
    rise           = row_nxt & ~(row_nxt << 1);
    ctrl_nxt.multi = |(rise & (rise - MAX_WIDTH'(1)));
    ctrl_nxt.draw  = outline_en_i || fill_en_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
    if (valid_i && ready_o) begin
      row_r   <= row_nxt;
      fgate_r <= fgate_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  assign valid_o = valid_r;
  assign row_o   = row_r;
  assign fgate_o = fgate_r;
  assign ctrl_o  = ctrl_r;

endmodule
`default_nettype wire

// ----- design/sof_walk.sv -----
// One walk stage: advances the inside, filled and parity flags over one segment of columns.
`default_nettype none
module sof_walk import sof_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int SEG_IDX   = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic [MAX_WIDTH-1:0] row_i,
  input  wire logic [MAX_WIDTH-1:0] fgate_i,
  input  wire logic [MAX_WIDTH-1:0] fill_i,
  input  wire row_ctrl_t            ctrl_i,
  input  wire walk_st_t             st_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic [MAX_WIDTH-1:0]      row_o,
  output logic [MAX_WIDTH-1:0]      fgate_o,
  output logic [MAX_WIDTH-1:0]      fill_o,
  output row_ctrl_t                 ctrl_o,
  output walk_st_t                  st_o
);

  localparam int LO  = SEG_IDX * SEG_W;
  localparam int LEN = (MAX_WIDTH - LO < SEG_W) ? (MAX_WIDTH - LO) : SEG_W;

  logic                 valid_r;
  logic [MAX_WIDTH-1:0] row_r;
  logic [MAX_WIDTH-1:0] fgate_r;
  logic [MAX_WIDTH-1:0] fill_r, fill_nxt;
  row_ctrl_t            ctrl_r;
  walk_st_t             st_r, st_nxt;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    st_nxt   = st_i;
    fill_nxt = fill_i;
    for (int b = 0; b < LEN; b++) begin
      st_nxt            = walk_step(st_nxt, row_i[LO+b], ctrl_i.multi);
      fill_nxt[LO+b]    = st_nxt.filled && fgate_i[LO+b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
    if (valid_i && ready_o) begin
      row_r   <= row_i;
      fgate_r <= fgate_i;
      fill_r  <= fill_nxt;
      ctrl_r  <= ctrl_i;
      st_r    <= st_nxt;
    end
  end

  assign valid_o = valid_r;
  assign row_o   = row_r;
  assign fgate_o = fgate_r;
  assign fill_o  = fill_r;
  assign ctrl_o  = ctrl_r;
  assign st_o    = st_r;

endmodule
`default_nettype wire

// ----- design/scanline_outline_fill_top.sv -----
// Top level of the scanline outline fill: configuration registers and the walk pipeline.
`default_nettype none
// Each transaction on the input carries one outline bitmap row; each result carries its fill
// mask and outline mask. A new row is taken in every cycle while the output is ready, so the
// sustained rate is one row per cycle. The pipeline has one front stage that clips the row and
// detects edges, then one stage for every eight columns of the left-to-right walk. Every stage
// has its own valid bit and holds its data under backpressure.
// Configuration writes take effect on rows accepted after the write.
module scanline_outline_fill_top import sof_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [ROW_W-1:0]      in_tdata,   // [63:0] row_bits
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [2*ROW_W-1:0]         out_tdata,  // [63:0] fill_mask, [127:64] outline_mask
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NSEG = (MAX_WIDTH + SEG_W - 1) / SEG_W;

  logic                  fill_en_r;
  logic                  outline_en_r;
  logic [CFG_DATA_W-1:0] row_width_r;

  logic                 valid [NSEG+1];
  logic                 ready [NSEG+1];
  logic [MAX_WIDTH-1:0] row   [NSEG+1];
  logic [MAX_WIDTH-1:0] fgate [NSEG+1];
  logic [MAX_WIDTH-1:0] fill  [NSEG+1];
  row_ctrl_t            ctrl  [NSEG+1];
  walk_st_t             st    [NSEG+1];

  logic [ROW_W-1:0] fill_ext;
  logic [ROW_W-1:0] outline_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_en_r    <= 1'b1;
      outline_en_r <= 1'b1;
      row_width_r  <= CFG_DATA_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILL_EN:    fill_en_r    <= cfg_wdata[0];
        CFG_OUTLINE_EN: outline_en_r <= cfg_wdata[0];
        CFG_ROW_WIDTH:  row_width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sof_prep #(.MAX_WIDTH(MAX_WIDTH)) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_i      (in_tvalid),
    .ready_o      (in_tready),
    .row_i        (in_tdata[MAX_WIDTH-1:0]),
    .fill_en_i    (fill_en_r),
    .outline_en_i (outline_en_r),
    .row_width_i  (row_width_r),
    .valid_o      (valid[0]),
    .ready_i      (ready[0]),
    .row_o        (row[0]),
    .fgate_o      (fgate[0]),
    .ctrl_o       (ctrl[0])
  );

  assign fill[0] = '0;
  assign st[0]   = '0;

  for (genvar k = 0; k < NSEG; k++) begin : g_walk
    sof_walk #(.MAX_WIDTH(MAX_WIDTH), .SEG_IDX(k)) u_walk (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .row_i   (row[k]),
      .fgate_i (fgate[k]),
      .fill_i  (fill[k]),
      .ctrl_i  (ctrl[k]),
      .st_i    (st[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .row_o   (row[k+1]),
      .fgate_o (fgate[k+1]),
      .fill_o  (fill[k+1]),
      .ctrl_o  (ctrl[k+1]),
      .st_o    (st[k+1])
    );
  end

  assign ready[NSEG] = out_tready;
  assign out_tvalid  = valid[NSEG];

  always_comb begin
    fill_ext                     = '0;
    outline_ext                  = '0;
    fill_ext[MAX_WIDTH-1:0]      = fill[NSEG];
    outline_ext[MAX_WIDTH-1:0]   = row[NSEG] & {MAX_WIDTH{ctrl[NSEG].draw}};
  end

  assign out_tdata = {outline_ext, fill_ext};

`ifndef SYNTHESIS
  a_fill_off_outline: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (fill[NSEG] & row[NSEG]) == '0)
    else $error("fill mask overlaps outline bits");

  a_single_edge_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !ctrl[NSEG].multi) |-> (fill[NSEG] == '0 && !st[NSEG].parity))
    else $error("row with fewer than two edges produced fill");

  a_filled_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && st[NSEG].filled) |-> st[NSEG].in_run)
    else $error("walk state filled while outside");
`endif

endmodule
`default_nettype wire
